// File: design/trd_pkg.sv
`default_nettype none

package trd_pkg;

  // History and window geometry
  localparam int HISTORY_DEPTH = 200;
  localparam int MAX_WINDOW    = 80;
  localparam int MIN_WINDOW    = 15;
  localparam int WINDOW_STEP   = 5;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 8;
  localparam int LIMIT_W = 4;
  localparam int RUN_W   = 4;

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_WINDOW + WINDOW_STEP + 1);

  localparam logic [RUN_W-1:0]   RUN_MAX        = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(3);
  localparam logic [CFG_W-1:0]   MIN_FILL_RESET = CFG_W'(40);

  // Configuration register indexes
  localparam logic [0:0] REG_REPEAT_LIMIT = 1'b0;
  localparam logic [0:0] REG_MIN_FILL     = 1'b1;

  typedef struct packed {
    logic              start;
    logic [PTR_W-1:0]  wr_pos;
    logic [FILL_W-1:0] fill;
    logic [CFG_W-1:0]  min_fill;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_rsp_t;

endpackage

`default_nettype wire

// File: design/trd_ram.sv
`default_nettype none

module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 200
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: design/trd_scan.sv
`default_nettype none

module trd_scan import trd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scan_req_t         req,
  output scan_rsp_t              rsp,
  output logic      [PTR_W-1:0]  rd_addr_a,
  output logic      [PTR_W-1:0]  rd_addr_b,
  input  wire logic [BYTE_W-1:0] rd_data_a,
  input  wire logic [BYTE_W-1:0] rd_data_b
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_WIN  = 2'd2;
  localparam logic [1:0] S_RUN  = 2'd3;

  localparam int FM_W = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int FL_W = (FILL_W > LEN_W + 1) ? FILL_W : LEN_W + 1;

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(HISTORY_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [1:0]       state;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] issue_cnt;
  logic [PTR_W-1:0] pa;
  logic [PTR_W-1:0] pb;
  logic             rd_vld;
  logic             rd_last;
  logic             meaningful;
  logic             done;
  logic             found;

  logic [PTR_W-1:0] pa_start;
  logic [PTR_W:0]   pb_sum;
  logic [PTR_W-1:0] pb_start;
  logic             issue;
  logic             mean_next;
  logic             too_short;
  logic             win_over;

  assign pa_start = ptr_dec(req.wr_pos);
  // newest minus len, wrapped into the circular history
  assign pb_sum   = {1'b0, pa_start} + (PTR_W+1)'(HISTORY_DEPTH) - (PTR_W+1)'(len);
  assign pb_start = (pb_sum >= (PTR_W+1)'(HISTORY_DEPTH)) ?
                    PTR_W'(pb_sum - (PTR_W+1)'(HISTORY_DEPTH)) : pb_sum[PTR_W-1:0];

  assign issue     = (state == S_RUN) && (issue_cnt < len);
  assign mean_next = meaningful | is_alnum(rd_data_a);
  assign too_short = FM_W'(req.fill) < FM_W'(req.min_fill);
  assign win_over  = (len > LEN_W'(MAX_WINDOW)) ||
                     ({FL_W'(len), 1'b0} > {1'b0, FL_W'(req.fill)});

  assign rd_addr_a = pa;
  assign rd_addr_b = pb;
  assign rsp       = '{done: done, found: found};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_vld  <= issue;
      rd_last <= issue && (issue_cnt == len - 1'b1);
      if (issue) begin
        pa        <= ptr_dec(pa);
        pb        <= ptr_dec(pb);
        issue_cnt <= issue_cnt + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req.start) begin
            len   <= LEN_W'(MIN_WINDOW);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (too_short) begin
            found <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_over) begin
            found <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            pa         <= pa_start;
            pb         <= pb_start;
            issue_cnt  <= '0;
            meaningful <= 1'b0;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (rd_vld) begin
            if (rd_data_a != rd_data_b) begin
              len   <= len + LEN_W'(WINDOW_STEP);
              state <= S_WIN;
            end else if (rd_last) begin
              if (mean_next) begin
                found <= 1'b1;
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                len   <= len + LEN_W'(WINDOW_STEP);
                state <= S_WIN;
              end
            end else begin
              meaningful <= mean_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/text_repetition_detector_unit.sv
// Text repetition detector.
// Input channel (s_*): one request per text item. s_tdata carries the byte,
// s_tuser says whether the byte is present, s_tlast marks the end of a chunk.
// Output channel (m_*): one request per chunk end, carrying the repeat flag,
// the running count of repeating chunks, the forward flag and the halt flag.
// Configuration channel (cfg_*): index 0 is the repeat limit, index 1 the
// minimum history fill; writes are taken every cycle, other indexes drop.
// Throughput: an item that is not a chunk end starts no scan, so the input
// stays ready. A chunk end walks the byte history in a single dual-read RAM,
// one byte pair per cycle: a check state tests the fill, then per window
// length a setup state and a compare run over the window, stopping early on
// the first mismatch; the walk ends on a match or once the lengths run out.
// The worst case compares all fourteen window lengths in full; a post state
// then hands the result to the output register.
// The output register decouples the two sides: the next item is accepted
// while a result waits; only a later chunk result stalls behind it.
// Reset clears the fill count, the write pointer, the run count, the halt
// state and the registers to limit 3, fill 40. The history RAM is not
// cleared; only written entries are ever compared.
// After the halting chunk, later items are accepted and dropped.
`default_nettype none

module text_repetition_detector_unit import trd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] text_byte
  input  wire logic              s_tuser,   // [0] byte_valid
  input  wire logic              s_tlast,   // chunk_end
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [7:0]        m_tdata,   // [0] repeat_found, [4:1] repeat_run,
                                            // [5] forward_chunk, [6] halted, [7] zero
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_SCAN = 2'd1;
  localparam logic [1:0] T_POST = 2'd2;

  logic [1:0]         state;
  logic [PTR_W-1:0]   wr_pos;
  logic [FILL_W-1:0]  fill;
  logic [RUN_W-1:0]   run_count;
  logic               stopped;
  logic [LIMIT_W-1:0] repeat_limit;
  logic [CFG_W-1:0]   min_fill;
  logic               found_q;

  logic               out_found;
  logic [RUN_W-1:0]   out_run;
  logic               out_halt;

  logic               accept;
  logic               wr_en;
  logic               start;
  logic               out_free;
  logic [RUN_W-1:0]   run_next;
  logic               halt_next;

  scan_req_t          req;
  scan_rsp_t          rsp;
  logic [PTR_W-1:0]   rd_addr_a;
  logic [PTR_W-1:0]   rd_addr_b;
  logic [BYTE_W-1:0]  rd_data_a;
  logic [BYTE_W-1:0]  rd_data_b;

  assign s_tready  = (state == T_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;
  assign wr_en     = accept & ~stopped & s_tuser;
  assign start     = accept & ~stopped & s_tlast;
  assign out_free  = ~m_tvalid | m_tready;

  // Count up saturating on a repeat, clear on anything else
  assign run_next  = ~found_q ? '0 :
                     (run_count == RUN_MAX) ? run_count : run_count + 1'b1;
  assign halt_next = found_q && (run_next >= repeat_limit);

  assign req = '{start: start, wr_pos: wr_pos, fill: fill, min_fill: min_fill};

  assign m_tdata = {1'b0, out_halt, ~out_halt, out_run, out_found};

  trd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_pos),
    .wdata   (s_tdata),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  trd_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_limit <= LIMIT_RESET;
      min_fill     <= MIN_FILL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REPEAT_LIMIT: repeat_limit <= cfg_data[LIMIT_W-1:0];
        REG_MIN_FILL:     min_fill     <= cfg_data;
        default:          ;
      endcase
    end
  end

  // History write pointer and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      fill   <= '0;
    end else if (wr_en) begin
      wr_pos <= (wr_pos == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
      if (fill < FILL_W'(HISTORY_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Output valid: raise on a posted result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == T_POST && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencing: accept, scan, post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      run_count <= '0;
      stopped   <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            state <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (rsp.done) begin
            found_q <= rsp.found;
            state   <= T_POST;
          end
        end
        T_POST: begin
          // hold until the output register is free
          if (out_free) begin
            out_found <= found_q;
            out_run   <= run_next;
            out_halt  <= halt_next;
            run_count <= run_next;
            stopped   <= halt_next;
            state     <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/trd_checker.sv
`default_nettype none

module trd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // No result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only the halting chunk is withheld from downstream
  a_halt_fwd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6] != m_tdata[5]))
    else $error("halt and forward flags disagree");

  // A non-repeating chunk clears the run count and does not halt
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[4:1] == 4'd0) && !m_tdata[6])
    else $error("run count not cleared on a non-repeat");

  // Nothing follows the halting result
  a_quiet_after_halt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[6] |=> !m_tvalid)
    else $error("result after halt");

endmodule

bind text_repetition_detector_unit trd_checker u_trd_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

`default_nettype wire

// File: bench/tb_text_repetition_detector_unit.sv
`timescale 1ns / 100ps

// Prediction of the repetition verdicts and the store of verdicts still owed
// by the block.
class repeat_tracker;

  typedef struct packed {
    logic       pad;
    logic       halted;
    logic       forward;
    logic [3:0] run;
    logic       found;
  } verdict_t;

  bit [7:0]    text_hist [trd_pkg::HISTORY_DEPTH];
  int unsigned wr_ptr;
  int unsigned fill;
  int unsigned run;
  int unsigned limit;
  int unsigned min_fill;
  bit          stopped;
  verdict_t    pending_verdicts [$];
  int unsigned mismatches;

  function new();
    wr_ptr     = 0;
    fill       = 0;
    run        = 0;
    stopped    = 0;
    limit      = 3;
    min_fill   = 40;
    mismatches = 0;
  endfunction

  // Age 0 is the newest byte; a candidate byte, if given, sits in front.
  function bit [7:0] aged_byte(int unsigned k, bit has_new, bit [7:0] nb);
    if (has_new) begin
      if (k == 0) return nb;
      k = k - 1;
    end
    return text_hist[(wr_ptr + trd_pkg::HISTORY_DEPTH - 1 - k) % trd_pkg::HISTORY_DEPTH];
  endfunction

  function bit is_word_char(bit [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function bit window_repeats(bit has_new, bit [7:0] nb);
    int unsigned f;
    int unsigned len;
    int unsigned k;
    bit          same;
    bit          word;
    bit [7:0]    a;
    f = fill + has_new;
    if (f > trd_pkg::HISTORY_DEPTH) f = trd_pkg::HISTORY_DEPTH;
    if (f < min_fill) return 0;
    for (len = trd_pkg::MIN_WINDOW; len <= trd_pkg::MAX_WINDOW && 2 * len <= f;
         len += trd_pkg::WINDOW_STEP) begin
      same = 1;
      word = 0;
      for (k = 0; k < len && same; k++) begin
        a = aged_byte(k, has_new, nb);
        if (a != aged_byte(k + len, has_new, nb)) same = 0;
        else if (is_word_char(a)) word = 1;
      end
      if (same && word) return 1;
    end
    return 0;
  endfunction

  // Would a chunk end carrying this item stop the stream?
  function bit halts_on(bit has_new, bit [7:0] nb);
    int unsigned next_run;
    if (stopped || !window_repeats(has_new, nb)) return 0;
    next_run = (run < 15) ? run + 1 : 15;
    return next_run >= limit;
  endfunction

  // A byte that differs from every byte a window would compare it against.
  function bit [7:0] breaking_byte();
    bit [7:0]    b;
    bit          clash;
    int unsigned len;
    do begin
      b     = $urandom_range(255, 0);
      clash = 0;
      for (len = trd_pkg::MIN_WINDOW; len <= trd_pkg::MAX_WINDOW; len += trd_pkg::WINDOW_STEP)
        if (len - 1 < fill && b == aged_byte(len - 1, 0, 8'h00)) clash = 1;
    end while (clash);
    return b;
  endfunction

  function void set_register(logic [0:0] idx, logic [7:0] value);
    if (idx == trd_pkg::REG_REPEAT_LIMIT) limit = value[3:0];
    else min_fill = value;
  endfunction

  function void note_request(bit [7:0] b, bit v, bit e);
    verdict_t vd;
    bit       hit;
    if (stopped) return;
    if (v) begin
      text_hist[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % trd_pkg::HISTORY_DEPTH;
      if (fill < trd_pkg::HISTORY_DEPTH) fill++;
    end
    if (!e) return;
    hit      = window_repeats(0, 8'h00);
    vd       = '0;
    vd.found = hit;
    if (hit) begin
      if (run < 15) run++;
      if (run >= limit) begin
        stopped   = 1;
        vd.halted = 1;
      end
    end else begin
      run = 0;
    end
    vd.run     = 4'(run);
    vd.forward = !vd.halted;
    pending_verdicts.insert(pending_verdicts.size(), vd);
  endfunction

  function void note_mismatch(string what, verdict_t want, verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected found=%0b run=%0d fwd=%0b halt=%0b pad=%0b, got found=%0b run=%0d fwd=%0b halt=%0b pad=%0b",
               what, want.found, want.run, want.forward, want.halted, want.pad,
               got.found, got.run, got.forward, got.halted, got.pad);
  endfunction

  function void check_verdict(logic [7:0] got_raw);
    verdict_t want;
    verdict_t got;
    got = got_raw;
    if (pending_verdicts.size() == 0) begin
      note_mismatch("result with no verdict pending", '0, got);
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.found !== want.found || got.run !== want.run || got.forward !== want.forward ||
        got.halted !== want.halted || got.pad !== want.pad)
      note_mismatch("verdict mismatch", want, got);
  endfunction

  function int unsigned outstanding();
    return pending_verdicts.size();
  endfunction

endclass

module tb_text_repetition_detector_unit;
  import trd_pkg::*;

  // Slowest correct run stays far below this even with every item a full scan.
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  // Long enough for a worst-case chunk-end scan to finish.
  localparam int unsigned DRAIN_CYCLES = 800;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef bit [7:0] text_q_t [$];

  // Opening requests as {chunk_end, byte_valid, text_byte}.
  localparam logic [9:0] OPENING [21] = '{
    10'h200,                                   // empty chunk end on empty history
    10'h100, 10'h1ff, 10'h130, 10'h139, 10'h341, // byte extremes, digits, chunk end
    10'h15a, 10'h161, 10'h17a,                 // letter edges
    10'h12f, 10'h13a, 10'h140, 10'h15b,        // neighbors of the letter and digit ranges
    10'h160, 10'h17b, 10'h180, 10'h37f,        // more range neighbors; high bytes are not word characters
    10'h000,                                   // nothing at all
    10'h200,                                   // empty chunk end below min fill
    10'h3aa, 10'h355
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;
  logic       s_tuser   = 1'b0;
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = REG_REPEAT_LIMIT;
  logic [7:0] cfg_data  = 8'h00;

  repeat_tracker tracker = new();

  int unsigned send_idle   = 0;
  int unsigned recv_idle   = 0;
  int unsigned items_sent  = 0;
  int unsigned cycles      = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 0;
  logic        hold_off_go = 1'b0;

  always #5 clk = ~clk;

  text_repetition_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_repetition_detector_unit verification failed");
      $finish;
    end
  end

  // Receiver: check every accepted verdict, then pick next cycle's ready.
  // A long hold-off, once asked for, keeps ready low so the output register
  // and then the input side back up.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_verdict(m_tdata);
    if (hold_off_go && !hold_done) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  function automatic bit [7:0] word_char();
    case ($urandom_range(2, 0))
      0:       return $urandom_range(8'h39, 8'h30);
      1:       return $urandom_range(8'h5a, 8'h41);
      default: return $urandom_range(8'h7a, 8'h61);
    endcase
  endfunction

  function automatic bit [7:0] other_char();
    case ($urandom_range(4, 0))
      0:       return $urandom_range(8'h2f, 8'h00);
      1:       return $urandom_range(8'h40, 8'h3a);
      2:       return $urandom_range(8'h60, 8'h5b);
      3:       return $urandom_range(8'h7f, 8'h7b);
      default: return $urandom_range(8'hff, 8'h80);
    endcase
  endfunction

  // Offer one request and hold it until taken. Unless a halt is wanted, a
  // chunk end that would stop the stream carries a byte that breaks the
  // repetition instead, so the run keeps producing verdicts.
  task automatic send_text(bit [7:0] b, bit v, bit e, bit may_halt);
    if (e && !may_halt && tracker.halts_on(v, b)) begin
      v = 1'b1;
      b = tracker.breaking_byte();
    end
    while ($urandom_range(99, 0) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= v;
    s_tlast  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(b, v, e);
    if (v || e) items_sent++;
  endtask

  // Cut text into chunks of a few bytes; sometimes close a chunk with an
  // empty chunk end, sometimes slip in a request that carries nothing.
  task automatic send_chunks(text_q_t text, bit may_halt);
    int unsigned i;
    int unsigned left;
    left = 0;
    for (i = 0; i < text.size(); i++) begin
      if (left == 0) left = $urandom_range(6, 1);
      if ($urandom_range(99, 0) < 3) send_text($urandom_range(255, 0), 1'b0, 1'b0, may_halt);
      left--;
      if (left != 0 && i + 1 != text.size()) begin
        send_text(text[i], 1'b1, 1'b0, may_halt);
      end else if ($urandom_range(99, 0) < 12) begin
        send_text(text[i], 1'b1, 1'b0, may_halt);
        send_text($urandom_range(255, 0), 1'b0, 1'b1, may_halt);
      end else begin
        send_text(text[i], 1'b1, 1'b1, may_halt);
      end
      left = (i + 1 == text.size()) ? 0 : left;
    end
  endtask

  // Mostly repeating motifs of every length, some with a corrupted byte,
  // some made only of non-word characters; the rest is plain noise.
  task automatic random_text(int unsigned quota, bit may_halt);
    text_q_t     text;
    bit [7:0]    motif [$];
    int unsigned target;
    int unsigned pick;
    int unsigned mlen;
    int unsigned total;
    int unsigned i;
    bit          plain;
    target = items_sent + quota;
    while (items_sent < target) begin
      pick = $urandom_range(99, 0);
      text.delete();
      motif.delete();
      if (pick < 75) begin
        case ($urandom_range(3, 0))
          0:       mlen = $urandom_range(14, 1);
          1:       mlen = $urandom_range(90, 15);
          default: mlen = MIN_WINDOW + WINDOW_STEP * $urandom_range(13, 0);
        endcase
        plain = (pick < 10);
        for (i = 0; i < mlen; i++)
          motif.insert(motif.size(), plain ? other_char() :
                       ($urandom_range(99, 0) < 15 ? 8'($urandom_range(255, 0)) :
                                                     word_char()));
        total = $urandom_range(2 * mlen + 60, 2 * mlen);
        if (total < 40) total = $urandom_range(70, 40);
        for (i = 0; i < total; i++) text.insert(text.size(), motif[i % mlen]);
        // Break the sequence at a random position.
        if (pick >= 62) text[$urandom_range(total - 1, 0)] ^= $urandom_range(255, 1);
      end else begin
        total = $urandom_range(40, 1);
        for (i = 0; i < total; i++) text.insert(text.size(), 8'($urandom_range(255, 0)));
      end
      send_chunks(text, may_halt);
    end
  endtask

  // Drop valid, wait for every owed verdict, then let any scan finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(idx, value);
  endtask

  // The limit takes the low four bits; the upper bits exercise the data bus.
  task automatic configure(logic [7:0] limit_val, logic [7:0] fill_val);
    write_register(REG_REPEAT_LIMIT, limit_val);
    write_register(REG_MIN_FILL, fill_val);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    text_q_t     text;
    int unsigned i;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening requests under the reset settings: limit 3, fill 40.
    for (i = 0; i < 21; i++)
      send_text(OPENING[i][7:0], OPENING[i][8], OPENING[i][9], 1'b0);

    // Sender idles often, receiver more often; checks from an empty fill.
    settle();
    configure(8'hf7, 8'h00);
    send_idle = 37;
    recv_idle = 75;
    random_text(270, 1'b0);

    // The other way round; checks only on a full history, widest limit.
    settle();
    configure(8'h0f, 8'hc8);
    send_idle = 75;
    recv_idle = 37;
    random_text(270, 1'b0);

    // Full speed, with one long receiver hold-off to back up the block.
    settle();
    configure(8'h12, 8'h1e);
    send_idle   = 0;
    recv_idle   = 0;
    hold_off_go <= 1'b1;
    random_text(220, 1'b0);

    // Fill threshold beyond the history: never a repeat.
    settle();
    configure(8'h01, 8'hff);
    random_text(40, 1'b0);

    // Limit of zero: the first repeating chunk halts, then everything drops.
    settle();
    configure(8'h00, 8'h28);
    for (i = 0; i < 20; i++) text.insert(text.size(), word_char());
    for (i = 20; i < 80; i++) text.insert(text.size(), text[i - 20]);
    send_chunks(text, 1'b1);
    for (i = 0; i < 30; i++)
      send_text($urandom_range(255, 0), $urandom_range(1, 0), $urandom_range(1, 0), 1'b1);

    settle();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("text_repetition_detector_unit verification clean");
    end else begin
      $display("text_repetition_detector_unit verification failed");
    end
    $finish;
  end

endmodule
